// ===== rtl/pmss_pkg.sv =====
// Shared constants, payload types and helpers of the point-mass step block.
`default_nettype none

package pmss_pkg;

    // Word format and register widths.
    localparam int WORD_BITS     = 32;
    localparam int LIMIT_BITS    = 31;
    localparam int STEP_BITS     = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;
    localparam int LANES         = 3;

    // Register values after reset.
    localparam logic [LIMIT_BITS-1:0] ACCEL_LIMIT_RST = 31'd327680;
    localparam logic [LIMIT_BITS-1:0] SPEED_LIMIT_RST = 31'd196608;
    localparam logic [STEP_BITS-1:0]  STEP_TIME_RST   = 16'd3277;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACCEL_LIMIT = 8'd0,
        CFG_SPEED_LIMIT = 8'd1,
        CFG_STEP_TIME   = 8'd2
    } t_cfg_idx;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef t_word [LANES-1:0] t_vec;

    // One input request.
    typedef struct packed {
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word vel_x;
        t_word vel_y;
        t_word vel_z;
        t_word cmd_acc_x;
        t_word cmd_acc_y;
        t_word cmd_acc_z;
    } t_req;

    // One result.
    typedef struct packed {
        t_word applied_acc_x;
        t_word applied_acc_y;
        t_word applied_acc_z;
        t_word new_pos_x;
        t_word new_pos_y;
        t_word new_pos_z;
        t_word new_vel_x;
        t_word new_vel_y;
        t_word new_vel_z;
    } t_result;

    // Saturate a value with three guard bits to the signed word range.
    function automatic t_word sat_word(input logic signed [WORD_BITS+2:0] x);
        t_word res;
        if ((x[WORD_BITS+2:WORD_BITS-1] == 4'b0000) ||
            (x[WORD_BITS+2:WORD_BITS-1] == 4'b1111)) begin
            res = x[WORD_BITS-1:0];
        end else if (x[WORD_BITS+2]) begin
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pmss_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module pmss_isqrt import pmss_pkg::*; #(
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [63:0]          i_rad,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_vld,
    output logic [31:0]          o_root,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int STEPS    = 32;
    localparam int REM_BITS = 36;

    logic [STEPS:1]          r_vld;
    logic [63:0]             r_rad  [1:STEPS];
    logic [REM_BITS-1:0]     r_rem  [1:STEPS];
    logic [31:0]             r_root [1:STEPS];
    logic [SIDE_BITS-1:0]    r_side [1:STEPS];

    logic [63:0]             s_rad  [0:STEPS-1];
    logic [REM_BITS-1:0]     s_rem  [0:STEPS-1];
    logic [31:0]             s_root [0:STEPS-1];
    logic [SIDE_BITS-1:0]    s_side [0:STEPS-1];
    logic [STEPS-1:0]        s_vld;

    logic [REM_BITS-1:0]     w_sh   [0:STEPS-1];
    logic [REM_BITS-1:0]     w_try  [0:STEPS-1];
    logic [63:0]             n_rad  [0:STEPS-1];
    logic [REM_BITS-1:0]     n_rem  [0:STEPS-1];
    logic [31:0]             n_root [0:STEPS-1];

    // Each stage brings down two radicand bits and decides one root bit.
    always_comb begin
        s_rad[0]  = i_rad;
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_side[0] = i_side;
        s_vld[0]  = i_vld;
        for (int k = 1; k < STEPS; k++) begin
            s_rad[k]  = r_rad[k];
            s_rem[k]  = r_rem[k];
            s_root[k] = r_root[k];
            s_side[k] = r_side[k];
            s_vld[k]  = r_vld[k];
        end
        for (int k = 0; k < STEPS; k++) begin
            w_sh[k]  = {s_rem[k][REM_BITS-3:0], s_rad[k][63:62]};
            w_try[k] = {2'b00, s_root[k], 2'b01};
            n_rad[k] = {s_rad[k][61:0], 2'b00};
            if (w_sh[k] >= w_try[k]) begin
                n_rem[k]  = w_sh[k] - w_try[k];
                n_root[k] = {s_root[k][30:0], 1'b1};
            end else begin
                n_rem[k]  = w_sh[k];
                n_root[k] = {s_root[k][30:0], 1'b0};
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= s_vld;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STEPS; k++) begin
            r_rad[k+1]  <= n_rad[k];
            r_rem[k+1]  <= n_rem[k];
            r_root[k+1] <= n_root[k];
            r_side[k+1] <= s_side[k];
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_root = r_root[STEPS];
    assign o_side = r_side[STEPS];

endmodule

`default_nettype wire

// ===== rtl/pmss_div.sv =====
// Pipelined restoring divider, three lanes over one divisor, one quotient bit per stage.
`default_nettype none

module pmss_div import pmss_pkg::*; #(
    parameter int SIDE_BITS = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [LANES-1:0][62:0] i_num,
    input  logic [31:0]           i_den,
    input  logic [SIDE_BITS-1:0]  i_side,
    output logic                  o_vld,
    output logic [LANES-1:0][30:0] o_quo,
    output logic [SIDE_BITS-1:0]  o_side
);

    localparam int STEPS = 31;

    logic [STEPS:1]                r_vld;
    logic [LANES-1:0][31:0]        r_rem  [1:STEPS];
    logic [LANES-1:0][30:0]        r_low  [1:STEPS];
    logic [LANES-1:0][30:0]        r_quo  [1:STEPS];
    logic [31:0]                   r_den  [1:STEPS];
    logic [SIDE_BITS-1:0]          r_side [1:STEPS];

    logic [LANES-1:0][31:0]        s_rem  [0:STEPS-1];
    logic [LANES-1:0][30:0]        s_low  [0:STEPS-1];
    logic [LANES-1:0][30:0]        s_quo  [0:STEPS-1];
    logic [31:0]                   s_den  [0:STEPS-1];
    logic [SIDE_BITS-1:0]          s_side [0:STEPS-1];
    logic [STEPS-1:0]              s_vld;

    logic [LANES-1:0][32:0]        w_sh   [0:STEPS-1];
    logic [LANES-1:0][31:0]        n_rem  [0:STEPS-1];
    logic [LANES-1:0][30:0]        n_low  [0:STEPS-1];
    logic [LANES-1:0][30:0]        n_quo  [0:STEPS-1];

    // The quotient is known to fit 31 bits, so the top dividend word starts the remainder.
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            s_rem[0][j] = i_num[j][62:31];
            s_low[0][j] = i_num[j][30:0];
        end
        s_quo[0]  = '0;
        s_den[0]  = i_den;
        s_side[0] = i_side;
        s_vld[0]  = i_vld;
        for (int k = 1; k < STEPS; k++) begin
            s_rem[k]  = r_rem[k];
            s_low[k]  = r_low[k];
            s_quo[k]  = r_quo[k];
            s_den[k]  = r_den[k];
            s_side[k] = r_side[k];
            s_vld[k]  = r_vld[k];
        end
        for (int k = 0; k < STEPS; k++) begin
            for (int j = 0; j < LANES; j++) begin
                w_sh[k][j]  = {s_rem[k][j], s_low[k][j][30]};
                n_low[k][j] = {s_low[k][j][29:0], 1'b0};
                if (w_sh[k][j] >= {1'b0, s_den[k]}) begin
                    n_rem[k][j] = 32'(w_sh[k][j] - {1'b0, s_den[k]});
                    n_quo[k][j] = {s_quo[k][j][29:0], 1'b1};
                end else begin
                    n_rem[k][j] = w_sh[k][j][31:0];
                    n_quo[k][j] = {s_quo[k][j][29:0], 1'b0};
                end
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= s_vld;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STEPS; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_low[k+1]  <= n_low[k];
            r_quo[k+1]  <= n_quo[k];
            r_den[k+1]  <= s_den[k];
            r_side[k+1] <= s_side[k];
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_quo  = r_quo[STEPS];
    assign o_side = r_side[STEPS];

endmodule

`default_nettype wire

// ===== rtl/pmss_clamp.sv =====
// Vector norm clamp: squares, compare, pipelined root and division.
`default_nettype none

module pmss_clamp import pmss_pkg::*; #(
    parameter int SIDE_BITS = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  t_vec                  i_vec,
    input  logic [LIMIT_BITS-1:0] i_limit,
    input  logic [SIDE_BITS-1:0]  i_side,
    output logic                  o_vld,
    output t_vec                  o_vec,
    output logic [SIDE_BITS-1:0]  o_side
);

    typedef struct packed {
        logic                              over;
        logic [LIMIT_BITS-1:0]             lim;
        logic [LANES-1:0][WORD_BITS-1:0]   mag;
        t_vec                              vec;
        logic [SIDE_BITS-1:0]              side;
    } t_root_side;

    typedef struct packed {
        logic                 over;
        t_vec                 vec;
        logic [SIDE_BITS-1:0] side;
    } t_div_side;

    localparam int ROOT_SIDE_BITS = $bits(t_root_side);
    localparam int DIV_SIDE_BITS  = $bits(t_div_side);

    // Stage 1: squares, magnitudes and the squared limit.
    logic signed [63:0]              w_sq  [LANES];
    logic [LANES-1:0][WORD_BITS-1:0] w_mag;
    logic [2*LIMIT_BITS-1:0]         w_lim2;

    logic                            r1_vld;
    logic [63:0]                     r1_sq [LANES];
    logic [LANES-1:0][WORD_BITS-1:0] r1_mag;
    logic [2*LIMIT_BITS-1:0]         r1_lim2;
    logic [LIMIT_BITS-1:0]           r1_lim;
    t_vec                            r1_vec;
    logic [SIDE_BITS-1:0]            r1_side;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_sq[j]  = 64'(i_vec[j]) * 64'(i_vec[j]);
            w_mag[j] = i_vec[j][WORD_BITS-1] ? (~i_vec[j] + 32'd1) : i_vec[j];
        end
        w_lim2 = (2*LIMIT_BITS)'(i_limit) * (2*LIMIT_BITS)'(i_limit);
    end

    // Stage 2: sum of squares against the squared limit.
    logic       r2_vld;
    logic [63:0] r2_sum;
    t_root_side r2_side;

    // Stage 3: magnitude times limit, root as divisor.
    t_root_side              w_rs;
    logic                    w_rt_vld;
    logic [31:0]             w_root;
    logic [ROOT_SIDE_BITS-1:0] w_rt_side;

    logic                    r3_vld;
    logic [LANES-1:0][62:0]  r3_num;
    logic [31:0]             r3_den;
    t_div_side               r3_side;

    logic                    w_dv_vld;
    logic [LANES-1:0][30:0]  w_quo;
    logic [DIV_SIDE_BITS-1:0] w_dv_side;
    t_div_side               w_ds;

    logic                    r4_vld;
    t_vec                    r4_vec;
    logic [SIDE_BITS-1:0]    r4_side;

    assign w_rs = t_root_side'(w_rt_side);
    assign w_ds = t_div_side'(w_dv_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= w_rt_vld;
            r4_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 1.
        for (int j = 0; j < LANES; j++) begin
            r1_sq[j] <= w_sq[j];
        end
        r1_mag  <= w_mag;
        r1_lim2 <= w_lim2;
        r1_lim  <= i_limit;
        r1_vec  <= i_vec;
        r1_side <= i_side;
        // Stage 2.
        r2_sum       <= r1_sq[0] + r1_sq[1] + r1_sq[2];
        r2_side.over <= (r1_sq[0] + r1_sq[1] + r1_sq[2]) > {2'b00, r1_lim2};
        r2_side.lim  <= r1_lim;
        r2_side.mag  <= r1_mag;
        r2_side.vec  <= r1_vec;
        r2_side.side <= r1_side;
        // Stage 3.
        for (int j = 0; j < LANES; j++) begin
            r3_num[j] <= 63'(w_rs.mag[j]) * 63'(w_rs.lim);
        end
        r3_den       <= w_root;
        r3_side.over <= w_rs.over;
        r3_side.vec  <= w_rs.vec;
        r3_side.side <= w_rs.side;
        // Output stage: scaled components keep the sign of the originals.
        for (int j = 0; j < LANES; j++) begin
            if (!w_ds.over) begin
                r4_vec[j] <= w_ds.vec[j];
            end else if (w_ds.vec[j][WORD_BITS-1]) begin
                r4_vec[j] <= -$signed({1'b0, w_quo[j]});
            end else begin
                r4_vec[j] <= $signed({1'b0, w_quo[j]});
            end
        end
        r4_side <= w_ds.side;
    end

    pmss_isqrt #(
        .SIDE_BITS (ROOT_SIDE_BITS)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_rad   (r2_sum),
        .i_side  (r2_side),
        .o_vld   (w_rt_vld),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    pmss_div #(
        .SIDE_BITS (DIV_SIDE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    assign o_vld  = r4_vld;
    assign o_vec  = r4_vec;
    assign o_side = r4_side;

endmodule

`default_nettype wire

// ===== rtl/point_mass_step_with_saturation_top.sv =====
// Top level: acceleration clamp, three integration stages, speed clamp.
//
//  channel   signals                                  direction  handshake
//  request   start, busy, i_req                       in         start & !busy
//  result    o_valid, o_result                        out        strobe, one cycle
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,   in         valid & ready
//            i_cfg_data
//
// A request is taken every cycle; busy stays low. Its result passes through the
// two norm clamps (32 root stages and 31 divide stages each) and the three
// integration stages. Reset clears all valid bits and loads the register
// defaults; the result side has no back-pressure.
`default_nettype none

module point_mass_step_with_saturation_top import pmss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_req                     i_req,
    output logic                     o_valid,
    output t_result                  o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int PAIR_BITS = 2 * $bits(t_vec);
    localparam logic signed [48:0] HALF49 = 49'sd1 <<< (STEP_BITS - 1);
    localparam logic signed [49:0] HALF50 = 50'sd1 <<< (STEP_BITS - 1);

    // Configuration registers.
    logic [LIMIT_BITS-1:0]  r_accel_limit;
    logic [LIMIT_BITS-1:0]  r_speed_limit;
    logic [STEP_BITS-1:0]   r_step_time;
    logic [2*STEP_BITS-1:0] r_dt2;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_limit <= ACCEL_LIMIT_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_step_time   <= STEP_TIME_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACCEL_LIMIT: r_accel_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_STEP_TIME:   r_step_time   <= i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Squared step, refreshed every cycle from the register.
    always_ff @(posedge i_clk) begin
        r_dt2 <= 32'(r_step_time) * 32'(r_step_time);
    end

    // Acceleration clamp; position and velocity ride along.
    t_vec                 w_cmd;
    t_vec                 w_pos;
    t_vec                 w_vel;
    logic                 w_ca_vld;
    t_vec                 w_acc;
    logic [PAIR_BITS-1:0] w_ca_side;

    assign w_pos = {i_req.pos_z, i_req.pos_y, i_req.pos_x};
    assign w_vel = {i_req.vel_z, i_req.vel_y, i_req.vel_x};
    assign w_cmd = {i_req.cmd_acc_z, i_req.cmd_acc_y, i_req.cmd_acc_x};

    pmss_clamp #(
        .SIDE_BITS (PAIR_BITS)
    ) u_acc_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_vec   (w_cmd),
        .i_limit (r_accel_limit),
        .i_side  ({w_pos, w_vel}),
        .o_vld   (w_ca_vld),
        .o_vec   (w_acc),
        .o_side  (w_ca_side)
    );

    // Integration stage 1: products with dt and dt squared.
    logic               r1_vld;
    t_vec               r1_acc;
    t_vec               r1_pos;
    t_vec               r1_vel;
    logic signed [47:0] r1_d [LANES];
    logic signed [63:0] r1_e [LANES];
    logic signed [47:0] r1_w [LANES];
    t_vec               w_ca_pos;
    t_vec               w_ca_vel;
    logic signed [47:0] w_d [LANES];
    logic signed [63:0] w_e [LANES];
    logic signed [47:0] w_w [LANES];

    assign {w_ca_pos, w_ca_vel} = w_ca_side;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_d[j] = 48'(w_acc[j]) * 48'($signed({1'b0, r_step_time}));
            w_e[j] = 64'(w_acc[j]) * 64'($signed({1'b0, r_dt2}));
            w_w[j] = 48'(w_ca_vel[j]) * 48'($signed({1'b0, r_step_time}));
        end
    end

    // Integration stage 2: position gain and rounded, saturated velocity.
    logic               r2_vld;
    t_vec               r2_acc;
    t_vec               r2_pos;
    t_vec               r2_vel;
    logic signed [49:0] r2_g [LANES];
    logic signed [48:0] w_dh [LANES];
    logic signed [49:0] w_g  [LANES];
    logic signed [34:0] w_vs [LANES];

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_dh[j] = $signed({r1_d[j][47], r1_d[j]}) + HALF49;
            w_g[j]  = $signed({{2{r1_w[j][47]}}, r1_w[j]})
                    + $signed({{3{r1_e[j][63]}}, r1_e[j][63:STEP_BITS+1]});
            w_vs[j] = $signed({{3{r1_vel[j][WORD_BITS-1]}}, r1_vel[j]})
                    + $signed({{2{w_dh[j][48]}}, w_dh[j][48:STEP_BITS]});
        end
    end

    // Integration stage 3: rounded, saturated position.
    logic               r3_vld;
    t_vec               r3_acc;
    t_vec               r3_pos;
    t_vec               r3_vel;
    logic signed [49:0] w_gh [LANES];
    logic signed [34:0] w_ps [LANES];

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_gh[j] = r2_g[j] + HALF50;
            w_ps[j] = $signed({{3{r2_pos[j][WORD_BITS-1]}}, r2_pos[j]})
                    + $signed({w_gh[j][49], w_gh[j][49:STEP_BITS]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= w_ca_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_acc <= w_acc;
        r1_pos <= w_ca_pos;
        r1_vel <= w_ca_vel;
        r2_acc <= r1_acc;
        r2_pos <= r1_pos;
        r3_acc <= r2_acc;
        for (int j = 0; j < LANES; j++) begin
            r1_d[j]   <= w_d[j];
            r1_e[j]   <= w_e[j];
            r1_w[j]   <= w_w[j];
            r2_g[j]   <= w_g[j];
            r2_vel[j] <= sat_word(w_vs[j]);
            r3_pos[j] <= sat_word(w_ps[j]);
        end
        r3_vel <= r2_vel;
    end

    // Speed clamp; acceleration and position ride along.
    logic                 w_cs_vld;
    t_vec                 w_nvel;
    logic [PAIR_BITS-1:0] w_cs_side;
    t_vec                 w_out_acc;
    t_vec                 w_out_pos;

    pmss_clamp #(
        .SIDE_BITS (PAIR_BITS)
    ) u_speed_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_vec   (r3_vel),
        .i_limit (r_speed_limit),
        .i_side  ({r3_acc, r3_pos}),
        .o_vld   (w_cs_vld),
        .o_vec   (w_nvel),
        .o_side  (w_cs_side)
    );

    assign {w_out_acc, w_out_pos} = w_cs_side;

    // Result ports come straight from the clamp's output register.
    assign o_valid                = w_cs_vld;
    assign o_result.applied_acc_x = w_out_acc[0];
    assign o_result.applied_acc_y = w_out_acc[1];
    assign o_result.applied_acc_z = w_out_acc[2];
    assign o_result.new_pos_x     = w_out_pos[0];
    assign o_result.new_pos_y     = w_out_pos[1];
    assign o_result.new_pos_z     = w_out_pos[2];
    assign o_result.new_vel_x     = w_nvel[0];
    assign o_result.new_vel_y     = w_nvel[1];
    assign o_result.new_vel_z     = w_nvel[2];

endmodule

`default_nettype wire
